// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// ----- rtl/core/ragbaby_pkg.sv -----
// Types, constants and helper functions for the Ragbaby character cipher.
// Used by ragbaby_shift, ragbaby_subst and ragbaby_cipher_char.
`default_nettype none

package ragbaby_pkg;

  localparam int KeyLength = 24;
  localparam int CodeW     = 5;
  localparam int CfgDataW  = 60;
  localparam int CfgIdxW   = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDecodeMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyLow     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh    = 2'd2;

  localparam logic [7:0] AsciiA      = 8'h61;
  localparam logic [7:0] AsciiZ      = 8'h7A;
  localparam logic [7:0] AsciiHyphen = 8'h2D;
  localparam logic [7:0] AsciiSpace  = 8'h20;

  localparam logic [CodeW-1:0] CodeI       = 5'd8;
  localparam logic [CodeW-1:0] CodeJ       = 5'd9;
  localparam logic [CodeW-1:0] CodeW_      = 5'd22;
  localparam logic [CodeW-1:0] CodeX       = 5'd23;
  localparam logic [CodeW-1:0] CodeLastLtr = 5'd25;

  typedef struct packed {
    logic [7:0] char_in;
    logic       start_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       char_out;
    logic [CodeW-1:0] shift_used;
  } out_word_t;

  // Word passed from the offset stage to the substitution stage
  typedef struct packed {
    logic [7:0]       ch;
    logic [CodeW-1:0] shift;
    logic             is_letter;
  } stage_t;

  typedef logic [KeyLength-1:0][CodeW-1:0] key_t;

  // Fold j onto i and x onto w
  function automatic logic [CodeW-1:0] fold_code(input logic [CodeW-1:0] c);
    logic [CodeW-1:0] r;
    r = c;
    if (c == CodeJ) r = CodeI;
    if (c == CodeX) r = CodeW_;
    return r;
  endfunction

  // Advance a shift modulo the key length
  function automatic logic [CodeW-1:0] wrap_inc(input logic [CodeW-1:0] v);
    logic [CodeW-1:0] r;
    r = (v == CodeW'(KeyLength - 1)) ? '0 : v + CodeW'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ragbaby_shift.sv -----
// Word-offset tracker and first pipeline register of the Ragbaby cipher.
// Depends on ragbaby_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ragbaby_shift import ragbaby_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_word_t in_word_i,
  input  wire logic     s2_ready_i,
  output logic          s1_valid_o,
  output stage_t        stage_o
);

  logic [CodeW-1:0] word_shift_q, word_shift_d;
  logic [CodeW-1:0] letter_shift_q, letter_shift_d;
  logic             between_q, between_d;
  logic             s1_valid_q, s1_valid_d;
  stage_t           stage_q, stage_d;
  logic             accept;

  logic [CodeW-1:0] ws, ls, base;
  logic             bw, is_letter;

  assign in_ready_o = !s1_valid_q || s2_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ws        = in_word_i.start_of_text ? CodeW'(1) : word_shift_q;
    ls        = in_word_i.start_of_text ? '0 : letter_shift_q;
    bw        = in_word_i.start_of_text ? 1'b1 : between_q;
    is_letter = (in_word_i.char_in >= AsciiA) && (in_word_i.char_in <= AsciiZ);
    base      = bw ? ws : ls;

    word_shift_d   = ws;
    letter_shift_d = ls;
    between_d      = bw;
    stage_d.ch        = in_word_i.char_in;
    stage_d.is_letter = is_letter;
    stage_d.shift     = '0;

    if (is_letter) begin
      stage_d.shift  = base;
      letter_shift_d = wrap_inc(base);
      if (bw) begin
        word_shift_d = wrap_inc(ws);
      end
      between_d = 1'b0;
    end else if (in_word_i.char_in != AsciiHyphen) begin
      between_d = 1'b1;
    end
  end

  assign s1_valid_d = accept ? 1'b1 : (s2_ready_i ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_shift_q   <= CodeW'(1);
      letter_shift_q <= '0;
      between_q      <= 1'b1;
      s1_valid_q     <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        word_shift_q   <= word_shift_d;
        letter_shift_q <= letter_shift_d;
        between_q      <= between_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign stage_o    = stage_q;

  `ASSERT_PROP(ShiftInRange, clk_i, rst_ni,
    s1_valid_q |-> (stage_q.shift < CodeW'(KeyLength)), "stage shift out of range")
  `ASSERT_PROP(NonLetterNoShift, clk_i, rst_ni,
    (s1_valid_q && !stage_q.is_letter) |-> (stage_q.shift == '0), "non-letter has a shift")
  `ASSERT_PROP(StageHoldsOnStall, clk_i, rst_ni,
    (s1_valid_q && !s2_ready_i) |=> (s1_valid_q && $stable(stage_q)), "stage lost on stall")

endmodule

`default_nettype wire

// ----- rtl/core/ragbaby_subst.sv -----
// Keyed-alphabet substitution and result register of the Ragbaby cipher.
// Depends on ragbaby_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ragbaby_subst import ragbaby_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   decode_i,
  input  wire key_t   key_i,
  input  wire logic   s1_valid_i,
  input  wire stage_t stage_i,
  output logic        s2_ready_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output out_word_t   out_word_o
);

  logic             out_valid_q;
  out_word_t        out_word_q, out_word_d;
  logic             take;
  logic [CodeW-1:0] want, pos, tgt;
  logic [CodeW:0]   sum, wrapped;
  logic [4:0]       idx;
  logic             found;

  assign s2_ready_o = !out_valid_q || out_ready_i;
  assign take       = s1_valid_i && s2_ready_o;

  // Highest key position holding the folded letter wins
  always_comb begin
    want  = fold_code(CodeW'(stage_i.ch - AsciiA));
    found = 1'b0;
    pos   = '0;
    for (int p = 0; p < KeyLength; p++) begin
      if ((key_i[p] <= CodeLastLtr) && (fold_code(key_i[p]) == want)) begin
        found = 1'b1;
        pos   = CodeW'(p);
      end
    end
  end

  always_comb begin
    if (decode_i) begin
      sum = {1'b0, pos} + (CodeW+1)'(KeyLength) - {1'b0, stage_i.shift};
    end else begin
      sum = {1'b0, pos} + {1'b0, stage_i.shift};
    end
    wrapped = (sum >= (CodeW+1)'(KeyLength)) ? sum - (CodeW+1)'(KeyLength) : sum;
    idx     = wrapped[4:0];
    tgt     = key_i[idx];

    out_word_d.shift_used = stage_i.shift;
    out_word_d.char_out   = stage_i.ch;
    if (stage_i.is_letter && !(decode_i && (stage_i.shift == '0))) begin
      out_word_d.char_out = AsciiSpace;
      if (found && (tgt <= CodeLastLtr)) begin
        out_word_d.char_out = AsciiA + 8'(tgt);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `ASSERT_PROP(ResultHoldsOnStall, clk_i, rst_ni,
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_word_q)),
    "result changed while stalled")
  `ASSERT_PROP(DecodeZeroPasses, clk_i, rst_ni,
    (take && decode_i && (stage_i.shift == '0)) |=>
      (out_word_q.char_out == $past(stage_i.ch)), "zero-shift decode altered character")
  `ASSERT_PROP(ShiftCarried, clk_i, rst_ni,
    take |=> (out_word_q.shift_used == $past(stage_i.shift)), "shift not carried to result")

endmodule

`default_nettype wire

// ----- rtl/core/ragbaby_cipher_char.sv -----
// Top level of the Ragbaby character cipher: configuration registers and pipeline.
// Depends on ragbaby_pkg, ragbaby_shift and ragbaby_subst.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_word_i) takes one ASCII character
//   per word, with start_of_text marking the first character of a new text.
//   Output channel (out_valid_o/out_ready_i/out_word_o) returns one word per
//   input word: the enciphered or deciphered character and the shift applied.
//   Configuration channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i)
//   writes decode mode (index 0) and the two key halves (indexes 1 and 2);
//   it is always ready; the user must use it only while the pipeline is empty, which the block itself does not enforce.
//   Path: an accepted word is registered in the offset register and then, once
//   the result register is free, in the result register, which drives
//   out_valid_o. Throughput: one word per cycle while out_ready_i stays high;
//   the offset tracker and the key compare are combinational logic in front of
//   their registers, so the pipeline takes a word every clock.
//   Stall: when the receiver holds ready low, the result register holds its
//   word, the offset stage fills, and then in_ready_o drops.
//   Reset: mode is encipher, every key position empty, the first word starts
//   at shift 1, and both pipeline stages are empty.
`default_nettype none

module ragbaby_cipher_char import ragbaby_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_word_t            in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_word_t                out_word_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic                decode_q;
  logic [CfgDataW-1:0] key_low_q, key_high_q;
  key_t                key;
  logic                s1_valid, s2_ready;
  stage_t              stage;

  // Writes are taken in any cycle; unknown indexes drop silently
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_q   <= 1'b0;
      key_low_q  <= '1;
      key_high_q <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDecodeMode: decode_q   <= cfg_data_i[0];
        CfgKeyLow:     key_low_q  <= cfg_data_i;
        CfgKeyHigh:    key_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Position p sits at bits 5p..5p+4 of the joined key
  assign key = {key_high_q, key_low_q};

  ragbaby_shift u_shift (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .s2_ready_i (s2_ready),
    .s1_valid_o (s1_valid),
    .stage_o    (stage)
  );

  ragbaby_subst u_subst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .decode_i    (decode_q),
    .key_i       (key),
    .s1_valid_i  (s1_valid),
    .stage_i     (stage),
    .s2_ready_o  (s2_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
